@@ sv/ftc_pkg.sv @@
package ftc_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;

  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int PROTO_W  = 8;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int BKT_OUT_W = 10;

  // Multiplier applied to the source address in the flow hash.
  localparam logic [IP_W-1:0] SRC_MULT = 32'd59;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_HIT       = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_DELETE  = 1'b1
  } op_t;

  typedef struct packed {
    logic [IP_W-1:0]    src_ip;
    logic [IP_W-1:0]    dst_ip;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [PROTO_W-1:0] proto;
  } flow_key_t;

endpackage

@@ sv/flow_table_count.sv @@
// Channel   Ports                                                 Direction
// --------  ----------------------------------------------------  ---------
// in        in_valid in_ready in_op in_src_ip in_dst_ip             input
//           in_src_port in_dst_port in_proto
// out       out_valid out_ready out_status out_bucket out_hit_count output
//
// Each item, from its transfer on, runs through the remainder steps, a valid-row read,
// a key read and a compare per way, a write-back, the output load and the idle state
// that takes the next transfer; only then is a new item taken. After reset the valid
// bits are swept one bucket row per cycle, with in_ready low. A result waits in the
// output register while the next item runs; the block stalls in its output state only
// when that register is still full.
module flow_table_count
  import ftc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [IP_W-1:0]      in_src_ip,
  input  logic [IP_W-1:0]      in_dst_ip,
  input  logic [PORT_W-1:0]    in_src_port,
  input  logic [PORT_W-1:0]    in_dst_port,
  input  logic [PROTO_W-1:0]   in_proto,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BKT_OUT_W-1:0] out_bucket,
  output logic [CNT_W-1:0]     out_hit_count
);

  localparam int SLOTS      = BUCKETS * WAYS;
  localparam int BW         = $clog2(BUCKETS);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_W      = $bits(flow_key_t);
  localparam int DIV_CYCLES = 3;
  localparam int DIV_W      = $clog2(DIV_CYCLES);

  // Fixed-point reciprocal of BUCKETS, less its implicit leading one, for an exact
  // 32-bit quotient: floor(2^32 * (2^BW - BUCKETS) / BUCKETS) + 1.
  localparam logic [2*IP_W-1:0] RECIP_WIDE =
    (((2*IP_W)'(1) << BW) - (2*IP_W)'(BUCKETS)) * ((2*IP_W)'(1) << IP_W) /
    (2*IP_W)'(BUCKETS) + (2*IP_W)'(1);
  localparam logic [IP_W-1:0]    RECIP     = IP_W'(RECIP_WIDE);
  localparam logic [BW-1:0]      BKT_LOW   = BW'(BUCKETS);
  localparam logic [BW-1:0]      BKT_LAST  = BW'(BUCKETS - 1);
  localparam logic [WAY_W-1:0]   WAY_LAST  = WAY_W'(WAYS - 1);
  localparam logic [DIV_W-1:0]   DIV_LAST  = DIV_W'(DIV_CYCLES - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_BASE = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // Storage. Valid bits sit one row per bucket so that a single read returns
  // the occupancy of the whole bucket; keys and counters sit one word per slot.
  logic [WAYS-1:0]  vld_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem [SLOTS];

  state_t           state_r, state_nxt;
  logic [BW-1:0]    clr_idx_r;
  flow_key_t        key_r;
  op_t              op_r;
  logic [IP_W-1:0]  hash_r;
  logic [IP_W-1:0]  mulhi_r;
  logic [IP_W-1:0]  quot_r, quot_nxt;
  logic [BW-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0] div_cnt_r;
  logic [SLOT_W-1:0] slot_r;
  logic [WAY_W-1:0] way_r;

  logic [WAYS-1:0]  vrow_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] cnt_q;

  logic              match_f_r, free_f_r;
  logic [SLOT_W-1:0] match_slot_r, free_slot_r;
  logic [WAY_W-1:0]  match_way_r, free_way_r;
  logic [CNT_W-1:0]  match_cnt_r;

  status_t          res_status_r;
  logic [CNT_W-1:0] res_cnt_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [BW-1:0]    out_bucket_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic              in_xfer;
  logic              out_load;
  logic [IP_W-1:0]   hash_in;
  logic [2*IP_W-1:0] recip_prod;
  logic              way_hit;
  logic [CNT_W-1:0]  cnt_inc;
  logic [WAYS-1:0]   vrow_wr;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Flow hash, formed directly on the input ports at the transfer.
  assign hash_in = IP_W'(in_src_ip * SRC_MULT) ^ in_dst_ip ^ {in_src_port, {PORT_W{1'b0}}} ^
                   IP_W'(in_dst_port) ^ IP_W'(in_proto);

  // Remainder by BUCKETS through a reciprocal multiplication, one step per cycle:
  // the high half of the hash times the reciprocal, then the quotient, then the
  // remainder from the low bits of the hash and of quotient times BUCKETS.
  assign recip_prod = {{IP_W{1'b0}}, hash_r} * {{IP_W{1'b0}}, RECIP};
  assign quot_nxt   = (mulhi_r + ((hash_r - mulhi_r) >> 1)) >> (BW - 1);
  assign rem_nxt    = hash_r[BW-1:0] - quot_r[BW-1:0] * BKT_LOW;

  assign way_hit = vrow_q[way_r] && (key_q == key_r);
  assign cnt_inc = (match_cnt_r == CNT_MAX) ? CNT_MAX : match_cnt_r + 1'b1;

  always_comb begin
    vrow_wr = vrow_q;
    if (op_r == OP_DELETE) begin
      vrow_wr[match_way_r] = 1'b0;
    end else begin
      vrow_wr[free_way_r] = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_idx_r == BKT_LAST) state_nxt = S_IDLE;
      S_IDLE: if (in_xfer) state_nxt = S_DIV;
      S_DIV:  if (div_cnt_r == DIV_LAST) state_nxt = S_BASE;
      S_BASE: state_nxt = S_RD;
      S_RD:   state_nxt = S_CMP;
      S_CMP:  state_nxt = (way_r == WAY_LAST) ? S_WR : S_RD;
      S_WR:   state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        key_r     <= '{src_ip: in_src_ip, dst_ip: in_dst_ip, src_port: in_src_port,
                       dst_port: in_dst_port, proto: in_proto};
        op_r      <= op_t'(in_op);
        hash_r    <= hash_in;
        div_cnt_r <= '0;
      end
      S_DIV: begin
        mulhi_r   <= recip_prod[2*IP_W-1:IP_W];
        quot_r    <= quot_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      S_BASE: begin
        slot_r    <= SLOT_W'(rem_r * WAYS);
        way_r     <= '0;
        match_f_r <= 1'b0;
        free_f_r  <= 1'b0;
      end
      S_CMP: begin
        if (way_hit && !match_f_r) begin
          match_f_r    <= 1'b1;
          match_slot_r <= slot_r;
          match_way_r  <= way_r;
          match_cnt_r  <= cnt_q;
        end else if (!vrow_q[way_r] && !free_f_r) begin
          free_f_r    <= 1'b1;
          free_slot_r <= slot_r;
          free_way_r  <= way_r;
        end
        slot_r <= slot_r + 1'b1;
        way_r  <= way_r + 1'b1;
      end
      S_WR: begin
        if (op_r == OP_OBSERVE) begin
          if (match_f_r) begin
            res_status_r <= ST_HIT;
            res_cnt_r    <= cnt_inc;
          end else if (free_f_r) begin
            res_status_r <= ST_INSERTED;
            res_cnt_r    <= '0;
          end else begin
            res_status_r <= ST_FULL;
            res_cnt_r    <= '0;
          end
        end else begin
          res_status_r <= match_f_r ? ST_DELETED : ST_NOT_FOUND;
          res_cnt_r    <= '0;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_r <= res_status_r;
      out_bucket_r <= rem_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  // Valid-bit memory: cleared row by row after reset, read once per item and
  // rewritten when an entry is added or removed.
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      vld_mem[clr_idx_r] <= '0;
    end else if (state_r == S_WR && ((op_r == OP_OBSERVE && !match_f_r && free_f_r) ||
                                     (op_r == OP_DELETE && match_f_r))) begin
      vld_mem[rem_r] <= vrow_wr;
    end
    if (state_r == S_BASE) begin
      vrow_q <= vld_mem[rem_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WR && op_r == OP_OBSERVE && !match_f_r && free_f_r) begin
      key_mem[free_slot_r] <= key_r;
    end
    if (state_r == S_RD) begin
      key_q <= key_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WR && op_r == OP_OBSERVE && (match_f_r || free_f_r)) begin
      cnt_mem[match_f_r ? match_slot_r : free_slot_r] <= match_f_r ? cnt_inc : '0;
    end
    if (state_r == S_RD) begin
      cnt_q <= cnt_mem[slot_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bucket    = BKT_OUT_W'(out_bucket_r);
  assign out_hit_count = out_cnt_r;

`ifndef SYNTHESIS
  a_xfer_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_DIV)
    else $error("accepted item did not enter the remainder unit");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BASE |-> $past(state_r, DIV_CYCLES) == S_DIV)
    else $error("remainder unit ran for the wrong number of cycles");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_HIT) |-> out_hit_count != '0)
    else $error("counted hit reports a zero counter");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_HIT) |-> out_hit_count == '0)
    else $error("result without a counted hit reports a nonzero counter");
`endif

endmodule

@@ bench/flow_table_monitor.sv @@
module flow_table_monitor
  import ftc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_op,
  input  logic [IP_W-1:0]      in_src_ip,
  input  logic [IP_W-1:0]      in_dst_ip,
  input  logic [PORT_W-1:0]    in_src_port,
  input  logic [PORT_W-1:0]    in_dst_port,
  input  logic [PROTO_W-1:0]   in_proto,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [BKT_OUT_W-1:0] out_bucket,
  input  logic [CNT_W-1:0]     out_hit_count,
  output int                   mismatch_count,
  output int                   pending_count
);

  localparam int SLOTS = BUCKETS * WAYS;

  typedef struct packed {
    status_t              status;
    logic [BKT_OUT_W-1:0] bucket;
    logic [CNT_W-1:0]     hit_count;
  } flow_result_t;

  // Shadow copy of the flow table; slot = bucket * WAYS + way.
  bit               slot_used [SLOTS];
  flow_key_t        slot_key  [SLOTS];
  logic [CNT_W-1:0] slot_count[SLOTS];

  flow_result_t pending_results[$];
  flow_result_t want;

  function automatic flow_result_t update_flow_table(op_t op, flow_key_t key);
    logic [IP_W-1:0] h;
    int unsigned     bkt;
    int              base;
    int              hit_way;
    int              free_way;
    int              s;
    flow_result_t    res;
    h = (key.src_ip * SRC_MULT) ^ key.dst_ip ^ {key.src_port, {PORT_W{1'b0}}} ^
        {{(IP_W-PORT_W){1'b0}}, key.dst_port} ^ {{(IP_W-PROTO_W){1'b0}}, key.proto};
    bkt = h % $unsigned(BUCKETS);
    base = bkt * WAYS;
    hit_way = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_used[base+w]) begin
        if (hit_way < 0 && slot_key[base+w] == key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    res.bucket = bkt[BKT_OUT_W-1:0];
    res.hit_count = '0;
    if (op == OP_OBSERVE) begin
      if (hit_way >= 0) begin
        s = base + hit_way;
        if (slot_count[s] != '1) slot_count[s] = slot_count[s] + 1'b1;
        res.hit_count = slot_count[s];
        res.status = ST_HIT;
      end else if (free_way >= 0) begin
        s = base + free_way;
        slot_used[s] = 1'b1;
        slot_key[s] = key;
        slot_count[s] = '0;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (hit_way >= 0) begin
        slot_used[base+hit_way] = 1'b0;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count = 0;
  end

  // The result is checked before the new item is predicted: a result never
  // belongs to an item taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d bucket %0d count %0d",
                     out_status, out_bucket, out_hit_count);
        end else begin
          want = pending_results.pop_front();
          if (want.status !== out_status || want.bucket !== out_bucket ||
              want.hit_count !== out_hit_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected status %0d bucket %0d count %0d, got %0d %0d %0d",
                       want.status, want.bucket, want.hit_count,
                       out_status, out_bucket, out_hit_count);
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(update_flow_table(op_t'(in_op),
          '{src_ip: in_src_ip, dst_ip: in_dst_ip, src_port: in_src_port,
            dst_port: in_dst_port, proto: in_proto}));
      pending_count = pending_results.size();
    end
  end

endmodule

@@ bench/flow_table_count_tb.sv @@
module flow_table_count_tb;
  import ftc_pkg::*;

  localparam int BUCKETS = BUCKETS_DEF;
  localparam int WAYS    = WAYS_DEF;
  // The slowest honest run, including the sweep of the valid bits after reset,
  // stays well under this limit; this leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 64;
  localparam int HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_op;
  logic [IP_W-1:0]      in_src_ip;
  logic [IP_W-1:0]      in_dst_ip;
  logic [PORT_W-1:0]    in_src_port;
  logic [PORT_W-1:0]    in_dst_port;
  logic [PROTO_W-1:0]   in_proto;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [BKT_OUT_W-1:0] out_bucket;
  logic [CNT_W-1:0]     out_hit_count;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;

  // Idle percentages for the two sides; the stimulus process sets them per
  // phase and the sender and receiver read them.
  int send_idle_pct;
  int recv_idle_pct;

  // The stimulus process asks once for a long receiver stall; the receiver
  // process counts that stall itself.
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  flow_key_t        flow_pool[POOL_SIZE];
  logic [IP_W-1:0]  hot_hash[4];

  always #4 clk = ~clk;

  flow_table_count #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_src_ip(in_src_ip), .in_dst_ip(in_dst_ip),
    .in_src_port(in_src_port), .in_dst_port(in_dst_port), .in_proto(in_proto),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_bucket(out_bucket), .out_hit_count(out_hit_count)
  );

  flow_table_monitor #(.BUCKETS(BUCKETS), .WAYS(WAYS)) monitor (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_src_ip(in_src_ip), .in_dst_ip(in_dst_ip),
    .in_src_port(in_src_port), .in_dst_port(in_dst_port), .in_proto(in_proto),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_bucket(out_bucket), .out_hit_count(out_hit_count),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  // A hung block or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic flow_key_t random_key();
    flow_key_t k;
    k.src_ip = $urandom;
    k.dst_ip = $urandom;
    k.src_port = PORT_W'($urandom_range(0, 65535));
    k.dst_port = PORT_W'($urandom_range(0, 65535));
    k.proto = PROTO_W'($urandom_range(0, 255));
    return k;
  endfunction

  // Rewrites the destination address so that the key hashes to exactly h.
  // Keys built this way on one h all share a bucket, which is how the
  // bucket-full and lowest-free-way cases are reached.
  function automatic flow_key_t key_on_hash(logic [IP_W-1:0] h, flow_key_t k);
    logic [IP_W-1:0] rest;
    rest = (k.src_ip * SRC_MULT) ^ {k.src_port, {PORT_W{1'b0}}} ^
           {{(IP_W-PORT_W){1'b0}}, k.dst_port} ^ {{(IP_W-PROTO_W){1'b0}}, k.proto};
    k.dst_ip = h ^ rest;
    return k;
  endfunction

  // Offers one item and returns at the falling edge after its transfer.
  // Valid is only lowered when the sender decides to idle, so a back-to-back
  // item keeps valid high without a second assignment in the same step.
  task automatic offer_flow(op_t op, flow_key_t k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_src_ip   <= k.src_ip;
    in_dst_ip   <= k.dst_ip;
    in_src_port <= k.src_port;
    in_dst_port <= k.dst_port;
    in_proto    <= k.proto;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: out_ready changes only at the falling edge. Besides the random
  // idling of the current phase, it honors one long stall, during which the
  // sender keeps offering items until the block backs up and drops in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    flow_key_t       zero_key;
    flow_key_t       ones_key;
    flow_key_t       crowd[WAYS+1];
    logic [IP_W-1:0] crowd_hash;
    int              r;
    int              idx;

    // Every input is known from time zero, while reset is held low.
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_OBSERVE;
    in_src_ip = '0;
    in_dst_ip = '0;
    in_src_port = '0;
    in_dst_port = '0;
    in_proto = '0;
    send_idle_pct = 16;
    recv_idle_pct = 81;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The all-zero and all-one keys cover the field extremes.
    // The first item waits out the valid-bit sweep that follows reset.
    zero_key = '0;
    ones_key = '1;
    offer_flow(OP_OBSERVE, zero_key);   // fresh insert reports a count of zero
    offer_flow(OP_OBSERVE, zero_key);   // first hit
    offer_flow(OP_OBSERVE, ones_key);
    offer_flow(OP_OBSERVE, ones_key);
    offer_flow(OP_DELETE, ones_key);    // delete of a present flow
    offer_flow(OP_DELETE, ones_key);    // delete of a flow that is gone
    offer_flow(OP_OBSERVE, ones_key);   // the freed way is reused

    // Fill one bucket past its ways, then free a middle way and check that
    // the overflow key lands in the lowest free way.
    crowd_hash = $urandom;
    for (int i = 0; i <= WAYS; i++) begin
      crowd[i] = key_on_hash(crowd_hash, random_key());
      offer_flow(OP_OBSERVE, crowd[i]);
    end
    offer_flow(OP_DELETE, crowd[WAYS > 1 ? 1 : 0]);
    offer_flow(OP_OBSERVE, crowd[WAYS]);
    offer_flow(OP_OBSERVE, crowd[0]);
    offer_flow(OP_OBSERVE, crowd[WAYS]);
    offer_flow(OP_DELETE, random_key());
    offer_flow(OP_DELETE, crowd[WAYS]);
    offer_flow(OP_OBSERVE, zero_key);

    // The random part works on a pool of flows, half of them crowded at first into
    // two of four hot buckets so that hits, deletes and full buckets are common.
    for (int i = 0; i < 4; i++) hot_hash[i] = $urandom;
    for (int i = 0; i < POOL_SIZE; i++)
      flow_pool[i] = (i % 2) ? key_on_hash(hot_hash[i % 4], random_key()) : random_key();

    for (int n = 0; n < 750; n++) begin
      if (n == 250) begin
        send_idle_pct = 81;
        recv_idle_pct = 16;
      end else if (n == 500) begin
        // No idling from here on, and the long receiver stall starts now.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
      end
      r = $urandom_range(0, 99);
      idx = $urandom_range(0, POOL_SIZE - 1);
      if (r < 45) begin
        offer_flow(OP_OBSERVE, flow_pool[idx]);
      end else if (r < 65) begin
        offer_flow(OP_DELETE, flow_pool[idx]);
      end else if (r < 82) begin
        flow_pool[idx] = key_on_hash(hot_hash[$urandom_range(0, 3)], random_key());
        offer_flow(OP_OBSERVE, flow_pool[idx]);
      end else begin
        // Fully random keys and operations reach every bit of every field.
        offer_flow(op_t'(1'($urandom_range(0, 1))), random_key());
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then a few item times more so that a
    // stray extra result would still be seen.
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
sv/ftc_pkg.sv
sv/flow_table_count.sv
bench/flow_table_monitor.sv
bench/flow_table_count_tb.sv
